// ===== sv/mtnc_pkg.sv =====
package mtnc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NAME_BYTES  = 20;

    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int TOP_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_W      = $clog2(NAME_BYTES);
    localparam int NAME_DEPTH = STACK_DEPTH * NAME_BYTES;
    localparam int NAME_AW    = $clog2(NAME_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_MISMATCH,
        ERR_EMPTY,
        ERR_OVERFLOW,
        ERR_TOO_LONG,
        ERR_UNCLOSED
    } err_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_START,
        OP_CMP,
        OP_CHECK
    } op_kind_t;

    typedef struct packed {
        logic [7:0]       text_byte;
        logic [POS_W-1:0] pos;
        op_kind_t         kind;
        logic             stack_empty;
        err_t             ferr;
        logic             more_open;
        logic             doc_end;
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       stored_byte;
        logic [POS_W-1:0] stored_len;
    } qent_t;

endpackage

// ===== sv/mtnc_in_if.sv =====
interface mtnc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       doc_end;

    modport source (output valid, output text_byte, output doc_end, input ready);
    modport sink (input valid, input text_byte, input doc_end, output ready);
endinterface

// ===== sv/mtnc_out_if.sv =====
interface mtnc_out_if;
    logic       valid;
    logic       ready;
    logic       done_res;
    logic       doc_valid;
    logic [2:0] error_code;

    modport source (output valid, output done_res, output doc_valid, output error_code,
                    input ready);
    modport sink (input valid, input done_res, input doc_valid, input error_code,
                  output ready);
endinterface

// ===== sv/mtnc_ram.sv =====
module mtnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/mtnc_front.sv =====
module mtnc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    mtnc_in_if.sink                  text,
    input  logic [mtnc_pkg::QCNT_W-1:0] q_count,
    output logic                     push,
    output mtnc_pkg::qent_t          push_data
);

    import mtnc_pkg::*;

    typedef enum logic [1:0] {
        M_OUTSIDE,
        M_FIRST,
        M_OPEN,
        M_CLOSE
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             halt_reg, halt_next;
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    op_t              op_next;

    logic             accept;
    logic             do_open;
    logic             do_close;
    logic             is_gt;
    logic             room;
    logic             too_long;
    logic [CNT_W-1:0] top_cnt;
    logic [TOP_W-1:0] top_idx;
    logic [TOP_W-1:0] push_idx;
    logic             name_we;
    logic             len_we;
    logic [NAME_AW-1:0] name_waddr;
    logic [NAME_AW-1:0] name_raddr;
    logic [7:0]       name_rdata;
    logic [POS_W-1:0] len_rdata;

    assign text.ready = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid_reg))
                        < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept = text.valid && text.ready;

    assign is_gt    = (text.text_byte == CH_GT);
    assign room     = (count_reg < CNT_W'(STACK_DEPTH));
    assign too_long = (pos_reg >= POS_W'(NAME_BYTES - 1));
    assign top_cnt  = count_reg - CNT_W'(1);
    assign top_idx  = top_cnt[TOP_W-1:0];
    assign push_idx = count_reg[TOP_W-1:0];

    assign name_waddr = NAME_AW'(push_idx) * NAME_AW'(NAME_BYTES) + NAME_AW'(pos_reg);
    assign name_raddr = NAME_AW'(top_idx) * NAME_AW'(NAME_BYTES) + NAME_AW'(pos_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        halt_next  = halt_reg;
        do_open    = 1'b0;
        do_close   = 1'b0;
        name_we    = 1'b0;
        len_we     = 1'b0;

        op_next.text_byte   = text.text_byte;
        op_next.pos         = pos_reg;
        op_next.kind        = OP_NONE;
        op_next.stack_empty = (count_reg == '0);
        op_next.ferr        = ERR_NONE;
        op_next.doc_end     = text.doc_end;

        if (!halt_reg)
        begin
            case (mode_reg)
                M_OUTSIDE:
                begin
                    if (text.text_byte == CH_LT)
                    begin
                        mode_next    = M_FIRST;
                        pos_next     = '0;
                        op_next.kind = OP_START;
                    end
                end
                M_FIRST:
                begin
                    if (text.text_byte == CH_SLASH)
                    begin
                        mode_next = M_CLOSE;
                    end
                    else
                    begin
                        mode_next = M_OPEN;
                        do_open   = 1'b1;
                    end
                end
                M_OPEN:
                begin
                    do_open = 1'b1;
                end
                M_CLOSE:
                begin
                    do_close = 1'b1;
                end
                default:
                begin
                    mode_next = M_OUTSIDE;
                end
            endcase
        end

        if (do_open)
        begin
            if (is_gt)
            begin
                mode_next = M_OUTSIDE;
                if (!room)
                begin
                    op_next.ferr = ERR_OVERFLOW;
                    halt_next    = 1'b1;
                end
                else
                begin
                    len_we     = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if (too_long)
            begin
                op_next.ferr = ERR_TOO_LONG;
                halt_next    = 1'b1;
            end
            else
            begin
                name_we  = accept && room;
                pos_next = pos_reg + POS_W'(1);
            end
        end

        if (do_close)
        begin
            if (is_gt)
            begin
                mode_next = M_OUTSIDE;
                if (count_reg == '0)
                begin
                    op_next.ferr = ERR_EMPTY;
                    halt_next    = 1'b1;
                end
                else
                begin
                    op_next.kind = OP_CHECK;
                    count_next   = top_cnt;
                end
            end
            else if (too_long)
            begin
                op_next.ferr = ERR_TOO_LONG;
                halt_next    = 1'b1;
            end
            else
            begin
                op_next.kind = OP_CMP;
                pos_next     = pos_reg + POS_W'(1);
            end
        end

        op_next.more_open = (count_next != '0);
    end

    mtnc_ram #(
        .WIDTH (8),
        .DEPTH (NAME_DEPTH)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (text.text_byte),
        .re    (accept),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    mtnc_ram #(
        .WIDTH (POS_W),
        .DEPTH (STACK_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (push_idx),
        .wdata (pos_reg),
        .re    (accept),
        .raddr (top_idx),
        .rdata (len_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_OUTSIDE;
            pos_reg      <= '0;
            count_reg    <= '0;
            halt_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (text.doc_end)
                begin
                    mode_reg  <= M_OUTSIDE;
                    pos_reg   <= '0;
                    count_reg <= '0;
                    halt_reg  <= 1'b0;
                end
                else
                begin
                    mode_reg  <= mode_next;
                    pos_reg   <= pos_next;
                    count_reg <= count_next;
                    halt_reg  <= halt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= op_next;
        end
    end

    assign push                  = s1_valid_reg;
    assign push_data.op          = s1_op_reg;
    assign push_data.stored_byte = name_rdata;
    assign push_data.stored_len  = len_rdata;

endmodule

// ===== sv/mtnc_queue.sv =====
module mtnc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  mtnc_pkg::qent_t             push_data,
    input  logic                        pop,
    output logic                        head_valid,
    output mtnc_pkg::qent_t             head,
    output logic [mtnc_pkg::QCNT_W-1:0] count
);

    import mtnc_pkg::*;

    qent_t             ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = ent_reg[rptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/mtnc_back.sv =====
module mtnc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mtnc_pkg::qent_t head,
    output logic            pop,
    mtnc_out_if.source      report
);

    import mtnc_pkg::*;

    err_t sticky_reg, sticky_next;
    logic bad_reg, bad_next;
    logic ov_reg;
    logic done_reg;
    logic dvalid_reg;
    err_t code_reg;
    err_t code_next;
    logic cmp_bad;

    assign pop = head_valid && (!ov_reg || report.ready);

    assign cmp_bad = head.op.stack_empty
                     || (head.op.pos >= head.stored_len)
                     || (head.stored_byte != head.op.text_byte);

    always_comb
    begin
        sticky_next = sticky_reg;
        bad_next    = bad_reg;
        if (sticky_reg == ERR_NONE)
        begin
            case (head.op.kind)
                OP_START:
                begin
                    bad_next = 1'b0;
                end
                OP_CMP:
                begin
                    if (cmp_bad)
                    begin
                        bad_next = 1'b1;
                    end
                end
                OP_CHECK:
                begin
                    if (bad_reg || (head.op.pos != head.stored_len))
                    begin
                        sticky_next = ERR_MISMATCH;
                    end
                end
                default:
                begin
                    if (head.op.ferr != ERR_NONE)
                    begin
                        sticky_next = head.op.ferr;
                    end
                end
            endcase
        end

        code_next = sticky_next;
        if (head.op.doc_end && (sticky_next == ERR_NONE) && head.op.more_open)
        begin
            code_next = ERR_UNCLOSED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg <= ERR_NONE;
            bad_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                ov_reg <= 1'b1;
                if (head.op.doc_end)
                begin
                    sticky_reg <= ERR_NONE;
                    bad_reg    <= 1'b0;
                end
                else
                begin
                    sticky_reg <= sticky_next;
                    bad_reg    <= bad_next;
                end
            end
            else if (report.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_reg   <= head.op.doc_end;
            dvalid_reg <= head.op.doc_end && (code_next == ERR_NONE);
            code_reg   <= code_next;
        end
    end

    assign report.valid      = ov_reg;
    assign report.done_res   = done_reg;
    assign report.doc_valid  = dvalid_reg;
    assign report.error_code = code_reg;

endmodule

// ===== sv/markup_tag_nesting_checker.sv =====
// Checks that the tags of a markup document nest correctly. The document arrives one byte per
// request on the text channel, with doc_end set on its final byte, and every byte yields one
// request on the report channel: the sticky error so far, or on the final byte the verdict, after
// which the checker is clear for the next document. The checker takes one byte per cycle while
// the queue has room; each result passes the front stage register, the queue and the result stage
// register. The front classifies each byte, reads the name store at the top stack entry, writes
// open names at the next free entry, and a four-entry queue ahead of the result stage lets text
// run on through report stalls until full. Open names are held in 16 entries of up to 19 bytes.
module markup_tag_nesting_checker (
    input logic        clk,
    input logic        rst_n,
    mtnc_in_if.sink    text,
    mtnc_out_if.source report
);

    import mtnc_pkg::*;

    logic              push;
    qent_t             push_data;
    logic              pop;
    logic              head_valid;
    qent_t             head;
    logic [QCNT_W-1:0] q_count;

    mtnc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    mtnc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    mtnc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .report     (report)
    );

endmodule

// ===== sv/mtnc_checker.sv =====
module mtnc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       done_res,
    input logic       doc_valid,
    input logic [2:0] error_code
);

    import mtnc_pkg::*;

    // A passing verdict only comes with the final byte and no error.
    a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && doc_valid) |-> (done_res && (error_code == ERR_NONE)))
        else $error("doc_valid without a clean final result");

    a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res && (error_code == ERR_NONE)) |-> doc_valid)
        else $error("clean final result not reported as valid");

    a_mid_doc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (!doc_valid && (error_code != ERR_UNCLOSED)
                                      && (error_code <= ERR_UNCLOSED)))
        else $error("bad result before the final byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(done_res)
                                       && $stable(doc_valid) && $stable(error_code)))
        else $error("stalled result changed");

endmodule

bind markup_tag_nesting_checker mtnc_checker u_mtnc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (report.valid),
    .out_ready  (report.ready),
    .done_res   (report.done_res),
    .doc_valid  (report.doc_valid),
    .error_code (report.error_code)
);
